// ===== hw/rtl/cmld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmld_pkg: shared types and constants of the motion level detector
// Widths of the fixed datapath, register indexes, level codes and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package cmld_pkg;

	// fixed field and datapath widths
	localparam int SMP_W   = 16;   // amplitude sample
	localparam int SMO_W   = 24;   // smoothed value, Q.8
	localparam int SQ_W    = 60;   // sum of squared deviations
	localparam int DVD_W   = 60;   // divider dividend / quotient
	localparam int DVS_W   = 42;   // divider divisor
	localparam int FEAT_W  = 32;   // variance and baseline
	localparam int SCORE_W = 16;
	localparam int ACT_W   = 15;
	localparam int LVL_W   = 2;
	localparam int DBC_W   = 4;    // debounce counters
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// level codes
	localparam logic [LVL_W-1:0] LVL_IDLE     = 2'd0;
	localparam logic [LVL_W-1:0] LVL_PRESENCE = 2'd1;
	localparam logic [LVL_W-1:0] LVL_MOTION   = 2'd2;
	localparam logic [LVL_W-1:0] LVL_HIGH     = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_THR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_CAL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FREEZE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_SENS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_FLOOR   = 3'd7;

	// register reset values
	localparam logic [15:0] RST_PRESENCE_THR = 16'd9830;
	localparam logic [15:0] RST_MOTION_THR   = 16'd22938;
	localparam logic [15:0] RST_HIGH_THR     = 16'd45875;
	localparam logic [15:0] RST_HYSTERESIS   = 16'd3277;
	localparam logic [15:0] RST_NORM_SENS    = 16'd256;
	localparam logic [31:0] RST_NORM_FLOOR   = 32'd1;

	typedef enum logic [1:0] {
		DIV_AVG  = 2'd0,
		DIV_MEAN = 2'd1,
		DIV_VAR  = 2'd2,
		DIV_NORM = 2'd3
	} div_op_t;

	typedef struct packed {
		logic [15:0] presence_thr;
		logic [15:0] motion_thr;
		logic [15:0] high_thr;
		logic [15:0] hysteresis;
		logic        auto_cal;
		logic        freeze;
		logic [15:0] norm_sens;
		logic [31:0] norm_floor;
	} cfg_t;

	typedef struct packed {
		logic    load;
		logic    med_rd;
		logic    tap_sh;
		logic    med_cap;
		logic    avg_upd;
		logic    div_start;
		div_op_t div_op;
		logic    smo_wr;
		logic    var_rd;
		logic    var_dif;
		logic    var_sq;
		logic    var_acc;
		logic    base_upd;
		logic    scl;
		logic    score_upd;
		logic    cls_upd;
		logic    act_upd;
	} cmd_t;

	typedef struct packed {
		logic frame_long;
		logic tap_full;
		logic pos_end;
		logic var_end;
		logic div_done;
	} sts_t;

	typedef struct packed {
		logic [LVL_W-1:0]   level;
		logic               presence;
		logic               changed;
		logic [SCORE_W-1:0] score;
		logic [ACT_W-1:0]   activity;
		logic [FEAT_W-1:0]  variance;
		logic [FEAT_W-1:0]  baseline;
		logic               calibrated;
	} res_t;

endpackage

// ===== hw/rtl/cmld_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmld_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cmld_ram #(
	parameter int W = 16,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/cmld_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmld_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses once, quotient holds until restart.
// ----------------------------------------------------------------------------
module cmld_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cmld_pkg::DVD_W-1:0] dividend,
	input  logic [cmld_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [cmld_pkg::DVD_W-1:0] quotient
);
	import cmld_pkg::*;

	localparam int IW = $clog2(DVD_W);

	logic          busy_q;
	logic          done_q;
	logic [IW-1:0] it_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   rem_n;
	logic             fits;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		rem_n = fits ? (trial - {1'b0, dvs_q}) : trial;
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			it_q   <= '0;
		end else if (busy_q) begin
			it_q <= it_q + 1'b1;
			if (it_q == IW'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= rem_n[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== hw/rtl/cmld_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmld_ctrl: frame sequencer
// Loads samples, then steps the datapath through median, average, variance,
// baseline, score, classifier and activity, and hands the result over.
// ----------------------------------------------------------------------------
module cmld_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last,
	input  logic           out_free,
	input  cmld_pkg::sts_t sts,
	output cmld_pkg::cmd_t cmd,
	output logic           in_ready,
	output logic           commit
);
	import cmld_pkg::*;

	typedef enum logic [20:0] {
		S_LOAD  = 21'h000001,
		S_MRD   = 21'h000002,
		S_MSH   = 21'h000004,
		S_MMED  = 21'h000008,
		S_MAVG  = 21'h000010,
		S_MDIVS = 21'h000020,
		S_DIVW  = 21'h000040,
		S_MWR   = 21'h000080,
		S_MEANS = 21'h000100,
		S_VRD   = 21'h000200,
		S_VDIF  = 21'h000400,
		S_VSQ   = 21'h000800,
		S_VACC  = 21'h001000,
		S_VDIVS = 21'h002000,
		S_BASE  = 21'h004000,
		S_SCL   = 21'h008000,
		S_NDIVS = 21'h010000,
		S_SCORE = 21'h020000,
		S_CLS   = 21'h040000,
		S_ACT   = 21'h080000,
		S_OUT   = 21'h100000
	} state_t;

	state_t  state_q, state_d;
	div_op_t op_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last && sts.frame_long) state_d = S_MRD;
				end
			end
			S_MRD: begin
				cmd.med_rd = 1'b1;
				state_d    = S_MSH;
			end
			S_MSH: begin
				cmd.tap_sh = 1'b1;
				state_d    = sts.tap_full ? S_MMED : S_MRD;
			end
			S_MMED: begin
				cmd.med_cap = 1'b1;
				state_d     = S_MAVG;
			end
			S_MAVG: begin
				cmd.avg_upd = 1'b1;
				state_d     = S_MDIVS;
			end
			S_MDIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_AVG;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (sts.div_done) begin
					case (op_q)
						DIV_AVG:  state_d = S_MWR;
						DIV_MEAN: state_d = S_VRD;
						DIV_VAR:  state_d = S_BASE;
						default:  state_d = S_SCORE;
					endcase
				end
			end
			S_MWR: begin
				cmd.smo_wr = 1'b1;
				state_d    = sts.pos_end ? S_MEANS : S_MRD;
			end
			S_MEANS: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_MEAN;
				state_d       = S_DIVW;
			end
			S_VRD: begin
				cmd.var_rd = 1'b1;
				state_d    = S_VDIF;
			end
			S_VDIF: begin
				cmd.var_dif = 1'b1;
				state_d     = S_VSQ;
			end
			S_VSQ: begin
				cmd.var_sq = 1'b1;
				state_d    = S_VACC;
			end
			S_VACC: begin
				cmd.var_acc = 1'b1;
				state_d     = sts.var_end ? S_VDIVS : S_VRD;
			end
			S_VDIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_VAR;
				state_d       = S_DIVW;
			end
			S_BASE: begin
				cmd.base_upd = 1'b1;
				state_d      = S_SCL;
			end
			S_SCL: begin
				cmd.scl = 1'b1;
				state_d = S_NDIVS;
			end
			S_NDIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_NORM;
				state_d       = S_DIVW;
			end
			S_SCORE: begin
				cmd.score_upd = 1'b1;
				state_d       = S_CLS;
			end
			S_CLS: begin
				cmd.cls_upd = 1'b1;
				state_d     = S_ACT;
			end
			S_ACT: begin
				cmd.act_upd = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			op_q    <= DIV_AVG;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) op_q <= cmd.div_op;
		end
	end

	// divider completes only while it is being waited on
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIVW)
		else $error("divider done outside wait state");

	// smoothed value is written right after its division
	a_wr_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MWR |-> $past(state_q) == S_DIVW)
		else $error("smoothed write without division");

endmodule

// ===== hw/rtl/cmld_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmld_dp: detector datapath
// Sample and smoothed-value stores, median taps, moving-average line,
// shared divider, variance accumulator, baseline, score and classifier.
// ----------------------------------------------------------------------------
module cmld_dp #(
	parameter int WINDOW         = 64,
	parameter int MEDIAN_TAPS    = 5,
	parameter int AVG_LEN        = 8,
	parameter int RISE_COUNT     = 3,
	parameter int FALL_COUNT     = 5,
	parameter int BASELINE_SHIFT = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmld_pkg::cmd_t             cmd,
	input  cmld_pkg::cfg_t             cfg,
	input  logic [cmld_pkg::SMP_W-1:0] amplitude,
	input  logic                       last,
	input  logic                       recalibrate,
	output cmld_pkg::sts_t             sts,
	output cmld_pkg::res_t             res
);
	import cmld_pkg::*;

	localparam int AW   = $clog2(WINDOW);
	localparam int NW   = $clog2(WINDOW + 1);
	localparam int HALF = MEDIAN_TAPS / 2;
	localparam int PW   = $clog2(WINDOW + MEDIAN_TAPS);
	localparam int AVW  = SMP_W + $clog2(AVG_LEN + 1);
	localparam int RKW  = $clog2(MEDIAN_TAPS + 1);
	localparam int DENW = $clog2(AVG_LEN + 1);
	localparam int SUMW = SMO_W + NW;

	// frame bookkeeping
	logic [NW-1:0] cnt_q, cnt_next, n_q, wi_q, vi_q;
	logic [PW-1:0] p_q;
	logic          recal_q;
	// median and average
	logic [SMP_W-1:0] taps_q [MEDIAN_TAPS];
	logic [SMP_W-1:0] line_q [AVG_LEN];
	logic [SMP_W-1:0] med_q, med_sel, oldest;
	logic [AVW-1:0]   acc_q;
	logic [DENW-1:0]  denom;
	logic [RKW-1:0]   rank;
	// variance
	logic [SUMW-1:0]    sum_q;
	logic [SMO_W-1:0]   mean_q, d_q;
	logic [2*SMO_W-1:0] prod_q;
	logic [SQ_W-1:0]    sq_q;
	logic [FEAT_W-1:0]  var_q, var_sat;
	logic [DVD_W:0]     var_rnd;
	// baseline and score
	logic [FEAT_W-1:0]  base_q, delta_q, base_n;
	logic [FEAT_W+15:0] bs_q;
	logic               seeded_q, cal_q, gt_q, seed;
	logic [SCORE_W-1:0] score_q, raw;
	logic [ACT_W-1:0]   act_q;
	logic [SCORE_W+6:0] inten;
	logic [LVL_W-1:0]   lvl_q, up_lvl, dn_lvl;
	logic [DBC_W-1:0]   rise_q, fall_q;
	logic [DBC_W:0]     rise_n, fall_n;
	logic               changed_q;
	logic [SCORE_W:0]   s_up, s_dn;
	// stores and divider
	logic [AW-1:0]    med_idx;
	logic [PW:0]      pm, n_ext;
	logic [SMP_W-1:0] smp_rd;
	logic [SMO_W-1:0] smo_rd;
	logic             div_done;
	logic [DVD_W-1:0] dvd, quo;
	logic [DVS_W-1:0] dvs;
	div_op_t          op_q;

	assign cnt_next = (32'(cnt_q) < WINDOW) ? cnt_q + 1'b1 : cnt_q;

	// status toward the sequencer
	always_comb begin
		sts.frame_long = 32'(cnt_next) >= WINDOW / 2;
		sts.tap_full   = 32'(p_q) >= MEDIAN_TAPS - 1;
		sts.pos_end    = {1'b0, p_q} == n_ext + (PW + 1)'(MEDIAN_TAPS - 1);
		sts.var_end    = vi_q == n_q - 1'b1;
		sts.div_done   = div_done;
	end

	// clamped tap address for the median stream
	always_comb begin
		n_ext = (PW + 1)'(n_q);
		pm    = {1'b0, p_q} - (PW + 1)'(HALF);
		if (32'(p_q) < HALF) med_idx = '0;
		else if (pm >= n_ext) med_idx = AW'(n_q - 1'b1);
		else med_idx = pm[AW-1:0];
	end

	cmld_ram #(.W(SMP_W), .D(WINDOW)) u_smp_ram (
		.clk   (clk),
		.we    (cmd.load && (32'(cnt_q) < WINDOW)),
		.waddr (cnt_q[AW-1:0]),
		.wdata (amplitude),
		.raddr (med_idx),
		.rdata (smp_rd)
	);

	cmld_ram #(.W(SMO_W), .D(WINDOW)) u_smo_ram (
		.clk   (clk),
		.we    (cmd.smo_wr),
		.waddr (wi_q[AW-1:0]),
		.wdata (quo[SMO_W-1:0]),
		.raddr (vi_q[AW-1:0]),
		.rdata (smo_rd)
	);

	// median: stable rank selection, plain copy below three taps
	always_comb begin
		med_sel = '0;
		rank    = '0;
		if (MEDIAN_TAPS < 3) begin
			med_sel = taps_q[HALF];
		end else begin
			for (int k = 0; k < MEDIAN_TAPS; k++) begin
				rank = '0;
				for (int j = 0; j < MEDIAN_TAPS; j++) begin
					if ((taps_q[j] < taps_q[k]) || ((j < k) && (taps_q[j] == taps_q[k])))
						rank = rank + 1'b1;
				end
				if (rank == RKW'(HALF)) med_sel = taps_q[k];
			end
		end
	end

	// moving average operands
	always_comb begin
		oldest = (32'(wi_q) >= AVG_LEN) ? line_q[AVG_LEN-1] : '0;
		denom  = (32'(wi_q) + 1 < AVG_LEN) ? DENW'(wi_q + 1'b1) : DENW'(AVG_LEN);
	end

	// divider operand select
	always_comb begin
		case (cmd.div_op)
			DIV_AVG: begin
				dvd = (DVD_W'(acc_q) << 8) + DVD_W'(denom >> 1);
				dvs = DVS_W'(denom);
			end
			DIV_MEAN: begin
				dvd = DVD_W'(sum_q) + DVD_W'(n_q >> 1);
				dvs = DVS_W'(n_q);
			end
			DIV_VAR: begin
				dvd = DVD_W'(sq_q);
				dvs = DVS_W'(n_q);
			end
			default: begin
				dvd = DVD_W'(delta_q) << 16;
				dvs = DVS_W'(bs_q >> 8) + DVS_W'(cfg.norm_floor) + DVS_W'(delta_q);
			end
		endcase
	end

	cmld_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	// variance rounding and saturation
	always_comb begin
		var_rnd = {1'b0, quo} + (DVD_W + 1)'(32768);
		var_sat = (|var_rnd[DVD_W:48]) ? '1 : var_rnd[47:16];
	end

	// baseline tracking
	always_comb begin
		seed = !seeded_q || recal_q;
		if (var_q >= base_q) base_n = base_q + ((var_q - base_q) >> BASELINE_SHIFT);
		else base_n = base_q - ((base_q - var_q) >> BASELINE_SHIFT);
	end

	// score, classifier and intensity
	always_comb begin
		raw    = !gt_q ? '0 : ((|quo[DVD_W-1:16]) ? '1 : quo[15:0]);
		s_up   = {1'b0, score_q};
		s_dn   = {1'b0, score_q} + {1'b0, cfg.hysteresis};
		if (s_up >= {1'b0, cfg.high_thr}) up_lvl = LVL_HIGH;
		else if (s_up >= {1'b0, cfg.motion_thr}) up_lvl = LVL_MOTION;
		else if (s_up >= {1'b0, cfg.presence_thr}) up_lvl = LVL_PRESENCE;
		else up_lvl = LVL_IDLE;
		if (s_dn >= {1'b0, cfg.high_thr}) dn_lvl = LVL_HIGH;
		else if (s_dn >= {1'b0, cfg.motion_thr}) dn_lvl = LVL_MOTION;
		else if (s_dn >= {1'b0, cfg.presence_thr}) dn_lvl = LVL_PRESENCE;
		else dn_lvl = LVL_IDLE;
		rise_n = {1'b0, rise_q} + 1'b1;
		fall_n = {1'b0, fall_q} + 1'b1;
		inten  = ((SCORE_W + 7)'(score_q) * (SCORE_W + 7)'(100) + (SCORE_W + 7)'(128)) >> 8;
	end

	// control and detector state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			recal_q   <= 1'b0;
			seeded_q  <= 1'b0;
			base_q    <= '0;
			score_q   <= '0;
			act_q     <= '0;
			lvl_q     <= LVL_IDLE;
			rise_q    <= '0;
			fall_q    <= '0;
			changed_q <= 1'b0;
			cal_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= last ? '0 : cnt_next;
				if (recalibrate) recal_q <= 1'b1;
			end
			if (cmd.base_upd) begin
				if (seed) begin
					base_q   <= var_q;
					seeded_q <= 1'b1;
					recal_q  <= 1'b0;
					lvl_q    <= LVL_IDLE;
					rise_q   <= '0;
					fall_q   <= '0;
					score_q  <= '0;
					act_q    <= '0;
					cal_q    <= 1'b1;
				end else begin
					cal_q <= 1'b0;
					if (cfg.auto_cal && (lvl_q == LVL_IDLE || !cfg.freeze)) base_q <= base_n;
				end
			end
			if (cmd.score_upd) begin
				score_q <= SCORE_W'(({2'b0, score_q} + {1'b0, score_q, 1'b0}
					+ (SCORE_W + 2)'(raw) + (SCORE_W + 2)'(2)) >> 2);
			end
			if (cmd.cls_upd) begin
				changed_q <= 1'b0;
				if (up_lvl > lvl_q) begin
					fall_q <= '0;
					if (32'(rise_n) >= RISE_COUNT) begin
						lvl_q     <= up_lvl;
						rise_q    <= '0;
						changed_q <= 1'b1;
					end else begin
						rise_q <= rise_n[DBC_W-1:0];
					end
				end else if (dn_lvl < lvl_q) begin
					rise_q <= '0;
					if (32'(fall_n) >= FALL_COUNT) begin
						lvl_q     <= dn_lvl;
						fall_q    <= '0;
						changed_q <= 1'b1;
					end else begin
						fall_q <= fall_n[DBC_W-1:0];
					end
				end else begin
					rise_q <= '0;
					fall_q <= '0;
				end
			end
			if (cmd.act_upd) begin
				act_q <= ACT_W'(({2'b0, act_q} + {1'b0, act_q, 1'b0}
					+ (ACT_W + 2)'(inten) + (ACT_W + 2)'(2)) >> 2);
			end
		end
	end

	// frame processing registers
	always_ff @(posedge clk) begin
		if (cmd.load && last) begin
			n_q   <= cnt_next;
			p_q   <= '0;
			wi_q  <= '0;
			vi_q  <= '0;
			acc_q <= '0;
			sum_q <= '0;
			sq_q  <= '0;
		end
		if (cmd.tap_sh) begin
			for (int k = 0; k < MEDIAN_TAPS - 1; k++) taps_q[k] <= taps_q[k+1];
			taps_q[MEDIAN_TAPS-1] <= smp_rd;
			p_q <= p_q + 1'b1;
		end
		if (cmd.med_cap) med_q <= med_sel;
		if (cmd.avg_upd) begin
			acc_q <= acc_q + AVW'(med_q) - AVW'(oldest);
			for (int k = AVG_LEN - 1; k > 0; k--) line_q[k] <= line_q[k-1];
			line_q[0] <= med_q;
		end
		if (cmd.div_start) op_q <= cmd.div_op;
		if (div_done && op_q == DIV_MEAN) mean_q <= quo[SMO_W-1:0];
		if (div_done && op_q == DIV_VAR) var_q <= var_sat;
		if (cmd.smo_wr) begin
			sum_q <= sum_q + SUMW'(quo[SMO_W-1:0]);
			wi_q  <= wi_q + 1'b1;
		end
		if (cmd.var_dif) d_q <= (smo_rd >= mean_q) ? smo_rd - mean_q : mean_q - smo_rd;
		if (cmd.var_sq) prod_q <= d_q * d_q;
		if (cmd.var_acc) begin
			sq_q <= sq_q + SQ_W'(prod_q);
			vi_q <= vi_q + 1'b1;
		end
		if (cmd.scl) begin
			bs_q    <= base_q * cfg.norm_sens;
			gt_q    <= var_q > base_q;
			delta_q <= var_q - base_q;
		end
	end

	always_comb begin
		res.level      = lvl_q;
		res.presence   = lvl_q != LVL_IDLE;
		res.changed    = changed_q;
		res.score      = score_q;
		res.activity   = act_q;
		res.variance   = var_q;
		res.baseline   = base_q;
		res.calibrated = cal_q;
	end

	// debounce counters clear as they reach their count
	a_rise_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rise_q) < RISE_COUNT)
		else $error("rise counter past its limit");

	a_fall_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fall_q) < FALL_COUNT)
		else $error("fall counter past its limit");

	// any processed frame leaves the baseline seeded
	a_seeded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.base_upd |=> seeded_q)
		else $error("baseline not seeded after update");

endmodule

// ===== hw/rtl/csi_motion_level_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csi_motion_level_detector: frame variance based motion level detector
// Config registers, output word register, sequencer and datapath.
// ----------------------------------------------------------------------------
// Samples load at one word per cycle while in_ready is high. A frame of
// n >= WINDOW/2 samples then yields a result word, and the single radix-2
// divider, which runs one division per smoothed sample, dominates its
// processing time. A shorter frame gives no word. The result sits in an
// output register, so the next frame loads while it waits to be taken.
// No clearing pass is needed after reset.
module csi_motion_level_detector #(
	parameter int WINDOW         = 64,
	parameter int MEDIAN_TAPS    = 5,
	parameter int AVG_LEN        = 8,
	parameter int RISE_COUNT     = 3,
	parameter int FALL_COUNT     = 5,
	parameter int BASELINE_SHIFT = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [15:0]                     amplitude,
	input  logic                            last,
	input  logic                            recalibrate,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      level,
	output logic                            presence,
	output logic                            changed,
	output logic [15:0]                     score,
	output logic [14:0]                     activity,
	output logic [31:0]                     variance,
	output logic [31:0]                     baseline,
	output logic                            calibrated,
	input  logic                            cfg_we,
	input  logic [cmld_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cmld_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cmld_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	res_t res, res_q;
	logic out_valid_q, out_free, commit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.presence_thr <= RST_PRESENCE_THR;
			cfg_q.motion_thr   <= RST_MOTION_THR;
			cfg_q.high_thr     <= RST_HIGH_THR;
			cfg_q.hysteresis   <= RST_HYSTERESIS;
			cfg_q.auto_cal     <= 1'b1;
			cfg_q.freeze       <= 1'b1;
			cfg_q.norm_sens    <= RST_NORM_SENS;
			cfg_q.norm_floor   <= RST_NORM_FLOOR;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESENCE_THR: cfg_q.presence_thr <= cfg_data[15:0];
				REG_MOTION_THR:   cfg_q.motion_thr   <= cfg_data[15:0];
				REG_HIGH_THR:     cfg_q.high_thr     <= cfg_data[15:0];
				REG_HYSTERESIS:   cfg_q.hysteresis   <= cfg_data[15:0];
				REG_AUTO_CAL:     cfg_q.auto_cal     <= cfg_data[0];
				REG_FREEZE:       cfg_q.freeze       <= cfg_data[0];
				REG_NORM_SENS:    cfg_q.norm_sens    <= cfg_data[15:0];
				REG_NORM_FLOOR:   cfg_q.norm_floor   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;

	cmld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready),
		.commit   (commit)
	);

	cmld_dp #(
		.WINDOW         (WINDOW),
		.MEDIAN_TAPS    (MEDIAN_TAPS),
		.AVG_LEN        (AVG_LEN),
		.RISE_COUNT     (RISE_COUNT),
		.FALL_COUNT     (FALL_COUNT),
		.BASELINE_SHIFT (BASELINE_SHIFT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.amplitude   (amplitude),
		.last        (last),
		.recalibrate (recalibrate),
		.sts         (sts),
		.res         (res)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) res_q <= res;
	end

	assign out_valid  = out_valid_q;
	assign level      = res_q.level;
	assign presence   = res_q.presence;
	assign changed    = res_q.changed;
	assign score      = res_q.score;
	assign activity   = res_q.activity;
	assign variance   = res_q.variance;
	assign baseline   = res_q.baseline;
	assign calibrated = res_q.calibrated;

	// a new word never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !(out_valid_q && !out_ready))
		else $error("result word overwritten");

endmodule
